// ----- rtl/core/tksd_pkg.sv -----
`default_nettype none

package tksd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC1  = 3'd1,
    PH_ESC2  = 3'd2,
    PH_TRAIL = 3'd3,
    PH_UTF   = 3'd4
  } phase_e;

  typedef enum logic [4:0] {
    KEY_TEXT      = 5'd0,
    KEY_CTRL_A    = 5'd1,
    KEY_CTRL_C    = 5'd2,
    KEY_CTRL_D    = 5'd3,
    KEY_CTRL_E    = 5'd4,
    KEY_CTRL_K    = 5'd5,
    KEY_CTRL_L    = 5'd6,
    KEY_CTRL_U    = 5'd7,
    KEY_CTRL_W    = 5'd8,
    KEY_TAB       = 5'd9,
    KEY_ENTER     = 5'd10,
    KEY_BACKSPACE = 5'd11,
    KEY_ESC       = 5'd12,
    KEY_DEL       = 5'd13,
    KEY_HOME      = 5'd14,
    KEY_END       = 5'd15,
    KEY_UP        = 5'd16,
    KEY_DOWN      = 5'd17,
    KEY_RIGHT     = 5'd18,
    KEY_LEFT      = 5'd19
  } key_e;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    key_e        key_code;
    logic [31:0] text_bytes;
    logic [2:0]  text_length;
  } out_item_t;

  // Parser state carried between the step logic and the state register.
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  intro_byte;
    logic [7:0]  digit_byte;
    logic [31:0] gathered_text;
    logic [1:0]  bytes_expected;
    logic [1:0]  bytes_gathered;
  } parse_state_t;

  localparam logic [7:0] CharEsc      = 8'd27;
  localparam logic [7:0] CharBracket  = 8'h5B;
  localparam logic [7:0] CharO        = 8'h4F;
  localparam logic [7:0] CharTilde    = 8'h7E;

endpackage

`default_nettype wire

// ----- rtl/core/tksd_step.sv -----
`default_nettype none

module tksd_step (
  input  wire tksd_pkg::parse_state_t state_i,
  input  wire tksd_pkg::in_item_t     item_i,
  output tksd_pkg::parse_state_t state_o,
  output logic                   emit_o,
  output tksd_pkg::out_item_t    result_o
);
  import tksd_pkg::*;

  logic [7:0]  c;
  logic        eoi;
  logic        ctrl_hit;
  key_e        ctrl_key;
  key_e        pair_key;
  key_e        trail_key;
  logic [1:0]  gathered_inc;
  logic [31:0] merged_text;

  assign c   = item_i.key_byte;
  assign eoi = item_i.end_of_input;

  always_comb begin
    ctrl_hit = 1'b1;
    ctrl_key = KEY_TEXT;
    unique case (c)
      8'd1:          ctrl_key = KEY_CTRL_A;
      8'd3:          ctrl_key = KEY_CTRL_C;
      8'd4:          ctrl_key = KEY_CTRL_D;
      8'd5:          ctrl_key = KEY_CTRL_E;
      8'd11:         ctrl_key = KEY_CTRL_K;
      8'd12:         ctrl_key = KEY_CTRL_L;
      8'd21:         ctrl_key = KEY_CTRL_U;
      8'd23:         ctrl_key = KEY_CTRL_W;
      8'd9:          ctrl_key = KEY_TAB;
      8'd10, 8'd13:  ctrl_key = KEY_ENTER;
      8'd8, 8'd127:  ctrl_key = KEY_BACKSPACE;
      default:       ctrl_hit = 1'b0;
    endcase
  end

  always_comb begin
    pair_key = KEY_ESC;
    if (state_i.intro_byte == CharBracket) begin
      unique case (c)
        8'h41:   pair_key = KEY_UP;
        8'h42:   pair_key = KEY_DOWN;
        8'h43:   pair_key = KEY_RIGHT;
        8'h44:   pair_key = KEY_LEFT;
        8'h48:   pair_key = KEY_HOME;
        8'h46:   pair_key = KEY_END;
        default: pair_key = KEY_ESC;
      endcase
    end else if (state_i.intro_byte == CharO) begin
      if (c == 8'h48) pair_key = KEY_HOME;
      else if (c == 8'h46) pair_key = KEY_END;
    end
  end

  always_comb begin
    trail_key = KEY_ESC;
    if (c == CharTilde) begin
      unique case (state_i.digit_byte)
        8'h33:        trail_key = KEY_DEL;
        8'h31, 8'h37: trail_key = KEY_HOME;
        8'h34, 8'h38: trail_key = KEY_END;
        default:      trail_key = KEY_ESC;
      endcase
    end
  end

  assign gathered_inc = state_i.bytes_gathered + 2'd1;
  assign merged_text  = state_i.gathered_text | ({24'd0, c} << {gathered_inc, 3'b000});

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{key_code: KEY_TEXT, text_bytes: 32'd0, text_length: 3'd0};

    unique case (state_i.phase)
      PH_ESC1: begin
        if (eoi) begin
          state_o.phase          = PH_IDLE;
          state_o.bytes_expected = 2'd0;
          state_o.bytes_gathered = 2'd0;
          emit_o                 = 1'b1;
          result_o.key_code      = KEY_ESC;
        end else begin
          state_o.intro_byte = c;
          state_o.phase      = PH_ESC2;
        end
      end
      PH_ESC2: begin
        if (!eoi && state_i.intro_byte == CharBracket && c >= 8'h30 && c <= 8'h39) begin
          state_o.digit_byte = c;
          state_o.phase      = PH_TRAIL;
        end else begin
          state_o.phase          = PH_IDLE;
          state_o.bytes_expected = 2'd0;
          state_o.bytes_gathered = 2'd0;
          emit_o                 = 1'b1;
          result_o.key_code      = eoi ? KEY_ESC : pair_key;
        end
      end
      PH_TRAIL: begin
        state_o.phase          = PH_IDLE;
        state_o.bytes_expected = 2'd0;
        state_o.bytes_gathered = 2'd0;
        emit_o                 = 1'b1;
        result_o.key_code      = eoi ? KEY_ESC : trail_key;
      end
      PH_UTF: begin
        if (eoi) begin
          // Only the lead byte survives an early end of input.
          state_o.phase          = PH_IDLE;
          state_o.bytes_expected = 2'd0;
          state_o.bytes_gathered = 2'd0;
          emit_o                 = 1'b1;
          result_o.text_bytes    = {24'd0, state_i.gathered_text[7:0]};
          result_o.text_length   = 3'd1;
        end else begin
          state_o.gathered_text  = merged_text;
          state_o.bytes_gathered = gathered_inc;
          if (gathered_inc >= state_i.bytes_expected) begin
            state_o.phase          = PH_IDLE;
            state_o.bytes_expected = 2'd0;
            state_o.bytes_gathered = 2'd0;
            emit_o                 = 1'b1;
            result_o.text_bytes    = merged_text;
            result_o.text_length   = {1'b0, state_i.bytes_expected} + 3'd1;
          end
        end
      end
      default: begin
        // Idle, and any phase code without meaning is handled as idle.
        state_o.phase          = PH_IDLE;
        state_o.bytes_expected = 2'd0;
        state_o.bytes_gathered = 2'd0;
        if (eoi) begin
          emit_o            = 1'b1;
          result_o.key_code = KEY_CTRL_D;
        end else if (ctrl_hit) begin
          emit_o            = 1'b1;
          result_o.key_code = ctrl_key;
        end else if (c == CharEsc) begin
          state_o.phase = PH_ESC1;
        end else if (c[7:5] == 3'b110 || c[7:4] == 4'b1110 || c[7:3] == 5'b11110) begin
          state_o.bytes_expected = (c[7:5] == 3'b110)  ? 2'd1 :
                                   (c[7:4] == 4'b1110) ? 2'd2 : 2'd3;
          state_o.gathered_text  = {24'd0, c};
          state_o.phase          = PH_UTF;
        end else begin
          emit_o               = 1'b1;
          result_o.text_bytes  = {24'd0, c};
          result_o.text_length = 3'd1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/terminal_key_sequence_decoder_core.sv -----
// Terminal key decoder core.
// The input channel (in_valid_i / in_ready_o / in_data_i) carries one raw
// terminal byte or an end-of-input mark per transfer. The output channel
// (out_valid_o / out_ready_i / out_data_o) carries decoded keys: a named key
// code, or a text character of one to four bytes. A transfer yields zero or
// one key; bytes inside an escape sequence or a multibyte character yield
// nothing until the sequence completes.
// A key passes from the input transfer that completes it through the input
// register and the combinational parser step into the output register.
// Throughput: one input transfer per cycle while the receiver does not stall,
// as the parser state is updated combinationally between the two registers.
// Reset empties both registers and returns the parser to idle.
// When the receiver stalls, the pending key holds in the output register; the
// next byte still enters the input register, and bytes that yield no key keep
// flowing through. A byte that yields a key waits in the input register, with
// in_ready_o low, until the output register frees.
`default_nettype none

module terminal_key_sequence_decoder_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire tksd_pkg::in_item_t in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tksd_pkg::out_item_t out_data_o
);
  import tksd_pkg::*;

  logic         s1_valid_q;
  in_item_t     s1_item_q;
  parse_state_t state_q;
  parse_state_t state_d;
  logic         emit;
  out_item_t    result;
  logic         s1_go;
  logic         out_free;
  logic         out_valid_q;
  out_item_t    out_item_q;

  tksd_step u_step (
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, intro_byte: 8'd0, digit_byte: 8'd0,
                   gathered_text: 32'd0, bytes_expected: 2'd0, bytes_gathered: 2'd0};
    end else if (s1_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_go && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_go && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

`ifndef SYNTH
  a_text_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_code == KEY_TEXT |->
      out_data_o.text_length != 3'd0 && out_data_o.text_length <= 3'd4)
    else $error("text key with bad length");

  a_named_key_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_code != KEY_TEXT |->
      out_data_o.text_length == 3'd0 && out_data_o.text_bytes == 32'd0)
    else $error("named key carries text");

  a_idle_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |->
      state_q.bytes_expected == 2'd0 && state_q.bytes_gathered == 2'd0)
    else $error("idle parser holds character counts");

  a_stalled_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_item_q) && $stable(state_q))
    else $error("stalled input item or parser state changed");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.key_code <= KEY_LEFT)
    else $error("key code out of range");
`endif

endmodule

`default_nettype wire
